[src/spmm_pkg.sv]
package spmm_pkg;

  localparam int unsigned RAM_BYTES = 131072;
  localparam int unsigned ROM_BYTES = 65536;

  localparam int unsigned PHYS_W = 17;

  typedef enum logic [1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_WRITE     = 2'd1,
    MODE_READ      = 2'd2,
    MODE_UNUSED    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REGION_RAM   = 2'd0,
    REGION_ROM   = 2'd1,
    REGION_IO    = 2'd2,
    REGION_EMPTY = 2'd3
  } region_t;

  typedef enum logic [1:0] {
    MOTOR_NONE  = 2'd0,
    MOTOR_START = 2'd1,
    MOTOR_STOP  = 2'd2,
    MOTOR_RSVD  = 2'd3
  } motor_t;

  localparam logic [15:0] BANK_SELECT_BIT = 16'h0800;
  localparam logic [15:0] ROM_SELECT_MASK = 16'h001b;
  localparam logic [7:0]  UPPER_ROM_PAGE0 = 8'h80;
  localparam logic [7:0]  UPPER_ROM_PAGE1 = 8'h81;
  localparam logic [7:0]  UPPER_ROM_PAGE2 = 8'h82;
  localparam logic [7:0]  UPPER_ROM_PAGE3 = 8'h83;
  localparam logic [15:0] READ_BASE       = 16'hc000;
  localparam logic [15:0] READ_TAPE_BIT   = 16'h0020;
  localparam logic [15:0] READ_KEY_BIT    = 16'h0040;
  localparam logic [15:0] READ_WRITTEN_BIT = 16'h0004;

  localparam logic [PHYS_W-1:0] RAM_MASK = PHYS_W'(RAM_BYTES - 1);
  localparam logic [PHYS_W-1:0] ROM_MASK = PHYS_W'(ROM_BYTES - 1);

  typedef struct packed {
    logic [7:0] upper_window;
    logic [2:0] lower_window_page;
  } window_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        beeper_level;
    logic [1:0]  motor_command;
  } port_result_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] cpu_address;
    logic [15:0] write_data;
    logic        low_byte_enable;
    logic        tape_running;
    logic        tape_recording;
    logic        tape_level_high;
    logic        key_held_flag;
  } item_t;

endpackage

[src/spmm_translate.sv]
module spmm_translate (
  input  logic                          disk_interface_present,
  input  spmm_pkg::window_t             window,
  input  logic [15:0]                   cpu_address,
  output logic [1:0]                    region,
  output logic [spmm_pkg::PHYS_W-1:0]   phys_address
);
  import spmm_pkg::*;

  logic [15:0]       a;
  logic [13:0]       off16;
  logic [12:0]       off8;
  region_t           r;
  logic [PHYS_W-1:0] p;

  always_comb begin
    a     = {cpu_address[15:1], 1'b0};
    off16 = a[13:0];
    off8  = a[12:0];
    if (a[15:14] == 2'b00) begin
      r = REGION_RAM;
      p = {3'd6, off16};
    end else if (a[15:14] == 2'b01) begin
      r = REGION_RAM;
      p = {window.lower_window_page, off16};
    end else if (a[15:14] == 2'b10) begin
      if (window.upper_window[7]) begin
        r = REGION_ROM;
        p = {1'b0, window.upper_window[1:0], off16};
      end else begin
        r = REGION_RAM;
        p = {window.upper_window[2:0], off16};
      end
    end else if (a[13] == 1'b0) begin
      r = REGION_ROM;
      p = {1'b0, 3'b100, off8};
    end else if (disk_interface_present) begin
      if (a[15:9] != 7'h7f) begin
        r = REGION_ROM;
        p = {1'b0, 3'b101, off8};
      end else begin
        r = REGION_IO;
        p = {1'b0, a};
      end
    end else begin
      if (a[15:8] != 8'hff) begin
        r = REGION_EMPTY;
        p = '0;
      end else begin
        r = REGION_IO;
        p = {1'b0, a};
      end
    end
    if (r == REGION_RAM) begin
      p = p & RAM_MASK;
    end else if (r == REGION_ROM) begin
      p = p & ROM_MASK;
    end
    region       = r;
    phys_address = p;
  end

endmodule

[src/spmm_port.sv]
module spmm_port (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  spmm_pkg::item_t        item,
  output spmm_pkg::window_t      window,
  output spmm_pkg::port_result_t result
);
  import spmm_pkg::*;

  window_t window_next;
  logic    port_written_flag;
  logic    port_written_flag_next;
  logic    beeper_state;
  logic    beeper_state_next;
  logic [15:0] val;

  always_comb begin
    val                    = item.write_data;
    window_next            = window;
    port_written_flag_next = port_written_flag;
    beeper_state_next      = beeper_state;
    result.read_data       = '0;
    result.motor_command   = MOTOR_NONE;
    unique case (mode_t'(item.mode))
      MODE_WRITE: begin
        if ((val & BANK_SELECT_BIT) != '0) begin
          if ((val & ROM_SELECT_MASK) != '0) begin
            priority if (val[4]) begin
              window_next.upper_window = UPPER_ROM_PAGE3;
            end else if (val[3]) begin
              window_next.upper_window = UPPER_ROM_PAGE2;
            end else if (val[1]) begin
              window_next.upper_window = UPPER_ROM_PAGE1;
            end else begin
              window_next.upper_window = UPPER_ROM_PAGE0;
            end
          end else begin
            window_next.upper_window = {5'd0, val[10:8]};
          end
          window_next.lower_window_page = val[14:12];
        end else if (item.low_byte_enable) begin
          if (!val[7] && !item.tape_running) begin
            result.motor_command = MOTOR_START;
          end else if (val[7] && item.tape_running && !item.tape_recording) begin
            result.motor_command = MOTOR_STOP;
          end
          beeper_state_next      = val[6];
          port_written_flag_next = 1'b1;
        end
      end
      MODE_READ: begin
        result.read_data = READ_BASE;
        if (port_written_flag) begin
          result.read_data       = result.read_data | READ_WRITTEN_BIT;
          port_written_flag_next = 1'b0;
        end
        if (item.tape_running && !item.tape_recording && item.tape_level_high) begin
          result.read_data = result.read_data | READ_TAPE_BIT;
        end
        if (!item.key_held_flag) begin
          result.read_data = result.read_data | READ_KEY_BIT;
        end
      end
      default: begin
      end
    endcase
    result.beeper_level = beeper_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window.upper_window      <= UPPER_ROM_PAGE0;
      window.lower_window_page <= '0;
      port_written_flag        <= 1'b0;
      beeper_state             <= 1'b0;
    end else if (step) begin
      window            <= window_next;
      port_written_flag <= port_written_flag_next;
      beeper_state      <= beeper_state_next;
    end
  end

endmodule

[src/system_port_memory_mapper_core.sv]
// System port and bank mapper. Each input word either translates a CPU address into a
// region and word-aligned physical address, writes the system port (bank select or
// beeper and tape motor control), reads the port, or in the unused mode changes no
// state. A word is taken into an input register, decoded combinationally against the
// current bank and port state, and lands in a result register; one word per cycle is
// sustained while the consumer takes results. The result register holds while the
// consumer stalls, and the input side keeps accepting as long as the decode stage can
// move. The disk interface register is written through the configuration channel,
// which is always ready.
module system_port_memory_mapper_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   mode,
  input  logic [15:0]                  cpu_address,
  input  logic [15:0]                  write_data,
  input  logic                         low_byte_enable,
  input  logic                         tape_running,
  input  logic                         tape_recording,
  input  logic                         tape_level_high,
  input  logic                         key_held_flag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   region,
  output logic [spmm_pkg::PHYS_W-1:0]  phys_address,
  output logic [15:0]                  read_data,
  output logic                         beeper_level,
  output logic [1:0]                   motor_command
);
  import spmm_pkg::*;

  logic              disk_interface_present;
  logic              stage_valid;
  item_t             stage;
  logic              advance;
  window_t           window;
  port_result_t      port_result;
  logic [1:0]        xlat_region;
  logic [PHYS_W-1:0] xlat_phys;

  assign cfg_ready = 1'b1;
  assign advance   = stage_valid && (!out_valid || out_ready);
  assign in_ready  = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_interface_present <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      disk_interface_present <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage.mode            <= mode;
      stage.cpu_address     <= cpu_address;
      stage.write_data      <= write_data;
      stage.low_byte_enable <= low_byte_enable;
      stage.tape_running    <= tape_running;
      stage.tape_recording  <= tape_recording;
      stage.tape_level_high <= tape_level_high;
      stage.key_held_flag   <= key_held_flag;
    end
  end

  spmm_port u_port (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (stage),
    .window (window),
    .result (port_result)
  );

  spmm_translate u_translate (
    .disk_interface_present (disk_interface_present),
    .window                 (window),
    .cpu_address            (stage.cpu_address),
    .region                 (xlat_region),
    .phys_address           (xlat_phys)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (stage.mode == MODE_TRANSLATE) begin
        region       <= xlat_region;
        phys_address <= xlat_phys;
      end else begin
        region       <= '0;
        phys_address <= '0;
      end
      read_data     <= port_result.read_data;
      beeper_level  <= port_result.beeper_level;
      motor_command <= port_result.motor_command;
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import spmm_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_WORDS  = 175;

  typedef struct packed {
    region_t           region;
    logic [PHYS_W-1:0] phys;
    logic [15:0]       rdata;
    logic              beep;
    motor_t            motor;
  } mapper_result_t;

  class mapper_scoreboard;
    mapper_result_t expected_q[$];
    int errors;
    int checked;
    int mode_count[4];
    bit disk_fitted;
    logic [7:0] upper_window;
    logic [2:0] lower_page;
    bit port_written;
    bit beeper;

    function new();
      errors = 0;
      checked = 0;
      foreach (mode_count[i]) mode_count[i] = 0;
      disk_fitted = 1'b0;
      upper_window = UPPER_ROM_PAGE0;
      lower_page = 3'd0;
      port_written = 1'b0;
      beeper = 1'b0;
    endfunction

    function void set_disk(bit fitted);
      disk_fitted = fitted;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function mapper_result_t map_address(logic [15:0] addr);
      mapper_result_t r;
      logic [15:0] a;
      r = '0;
      a = addr & 16'hfffe;
      if (a < 16'h4000) begin
        r.region = REGION_RAM;
        r.phys = {3'd6, a[13:0]};
      end else if (a < 16'h8000) begin
        r.region = REGION_RAM;
        r.phys = {lower_page, a[13:0]};
      end else if (a < 16'hc000) begin
        if (upper_window[7]) begin
          r.region = REGION_ROM;
          r.phys = {1'b0, upper_window[1:0], a[13:0]};
        end else begin
          r.region = REGION_RAM;
          r.phys = {upper_window[2:0], a[13:0]};
        end
      end else if (a < 16'he000) begin
        r.region = REGION_ROM;
        r.phys = {4'b0100, a[12:0]};
      end else if (disk_fitted && a < 16'hfe00) begin
        r.region = REGION_ROM;
        r.phys = {4'b0101, a[12:0]};
      end else if (!disk_fitted && a < 16'hff00) begin
        r.region = REGION_EMPTY;
        r.phys = '0;
      end else begin
        r.region = REGION_IO;
        r.phys = {1'b0, a};
      end
      return r;
    endfunction

    function void note_word(item_t w);
      mapper_result_t r;
      r = '0;
      mode_count[w.mode]++;
      case (mode_t'(w.mode))
        MODE_TRANSLATE: r = map_address(w.cpu_address);
        MODE_WRITE: begin
          if ((w.write_data & BANK_SELECT_BIT) != 0) begin
            if ((w.write_data & ROM_SELECT_MASK) != 0) begin
              if (w.write_data[4]) upper_window = UPPER_ROM_PAGE3;
              else if (w.write_data[3]) upper_window = UPPER_ROM_PAGE2;
              else if (w.write_data[1]) upper_window = UPPER_ROM_PAGE1;
              else upper_window = UPPER_ROM_PAGE0;
            end else begin
              upper_window = {5'd0, w.write_data[10:8]};
            end
            lower_page = w.write_data[14:12];
          end else if (w.low_byte_enable) begin
            if (!w.write_data[7] && !w.tape_running) r.motor = MOTOR_START;
            else if (w.write_data[7] && w.tape_running && !w.tape_recording) r.motor = MOTOR_STOP;
            beeper = w.write_data[6];
            port_written = 1'b1;
          end
        end
        MODE_READ: begin
          r.rdata = READ_BASE;
          if (port_written) begin
            r.rdata |= READ_WRITTEN_BIT;
            port_written = 1'b0;
          end
          if (w.tape_running && !w.tape_recording && w.tape_level_high) r.rdata |= READ_TAPE_BIT;
          if (!w.key_held_flag) r.rdata |= READ_KEY_BIT;
        end
        default: ;
      endcase
      r.beep = beeper;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        errors++;
        $error("%s: expected 0x%0h, actual 0x%0h", name, exp, act);
      end
    endfunction

    function void check_word(mapper_result_t got);
      mapper_result_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result word arrived with no word pending");
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      compare_field("region", 32'(exp.region), 32'(got.region));
      compare_field("phys_address", 32'(exp.phys), 32'(got.phys));
      compare_field("read_data", 32'(exp.rdata), 32'(got.rdata));
      compare_field("beeper_level", 32'(exp.beep), 32'(got.beep));
      compare_field("motor_command", 32'(exp.motor), 32'(got.motor));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] mode = '0;
  logic [15:0] cpu_address = '0;
  logic [15:0] write_data = '0;
  logic low_byte_enable = 1'b0;
  logic tape_running = 1'b0;
  logic tape_recording = 1'b0;
  logic tape_level_high = 1'b0;
  logic key_held_flag = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] region;
  logic [PHYS_W-1:0] phys_address;
  logic [15:0] read_data;
  logic beeper_level;
  logic [1:0] motor_command;

  mapper_scoreboard sb = new();
  bit sender_quiet = 1'b0;
  bit receiver_quiet = 1'b0;
  bit result_taken = 1'b0;
  int out_hold = 0;
  int idle_cycles = 0;
  int cfg_writes = 0;

  system_port_memory_mapper_core u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (result_taken) out_hold = receiver_quiet ? 0 : $urandom_range(0, 12);
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold = out_hold - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_taken = !rst && out_valid && out_ready;
    if (result_taken) begin
      sb.check_word('{region_t'(region), phys_address, read_data, beeper_level,
                      motor_t'(motor_command)});
    end
    if (result_taken || (in_valid && in_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $error("no progress for %0d cycles, %0d results still expected", IDLE_LIMIT,
             sb.pending());
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic item_t word_of(mode_t m, logic [15:0] addr, logic [15:0] data,
                                    logic [4:0] flags);
    item_t w;
    w.mode = m;
    w.cpu_address = addr;
    w.write_data = data;
    {w.low_byte_enable, w.tape_running, w.tape_recording, w.tape_level_high,
     w.key_held_flag} = flags;
    return w;
  endfunction

  function automatic item_t random_word();
    item_t w;
    int pick;
    logic [15:0] base;
    w.cpu_address = 16'($urandom);
    w.write_data = 16'($urandom);
    w.low_byte_enable = ($urandom_range(0, 4) != 0);
    w.tape_running = 1'($urandom);
    w.tape_recording = 1'($urandom);
    w.tape_level_high = 1'($urandom);
    w.key_held_flag = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) w.mode = MODE_TRANSLATE;
    else if (pick < 75) w.mode = MODE_WRITE;
    else if (pick < 95) w.mode = MODE_READ;
    else w.mode = MODE_UNUSED;
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 6))
        0: base = 16'h0000;
        1: base = 16'h4000;
        2: base = 16'h8000;
        3: base = 16'hc000;
        4: base = 16'he000;
        5: base = 16'hfe00;
        default: base = 16'hff00;
      endcase
      w.cpu_address = base + 16'($urandom_range(0, 7)) - 16'd4;
    end
    if (w.mode == MODE_WRITE) begin
      w.write_data[11] = 1'($urandom_range(0, 1));
      if (w.write_data[11] && $urandom_range(0, 9) < 4) w.write_data &= ~ROM_SELECT_MASK;
    end
    return w;
  endfunction

  task automatic send_word(item_t w);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= w.mode;
    cpu_address <= w.cpu_address;
    write_data <= w.write_data;
    low_byte_enable <= w.low_byte_enable;
    tape_running <= w.tape_running;
    tape_recording <= w.tape_recording;
    tape_level_high <= w.tape_level_high;
    key_held_flag <= w.key_held_flag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_disk(bit fitted);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= fitted;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_disk(fitted);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed words: region edges, bank selects, port writes and reads.
    send_word(word_of(MODE_TRANSLATE, 16'h0001, 16'h0000, 5'b00000));
    send_word(word_of(MODE_TRANSLATE, 16'h3fff, 16'hffff, 5'b11111));
    send_word(word_of(MODE_TRANSLATE, 16'h4000, 16'h0000, 5'b00000));
    send_word(word_of(MODE_TRANSLATE, 16'h8000, 16'h0000, 5'b00000));
    send_word(word_of(MODE_TRANSLATE, 16'hbfff, 16'h0000, 5'b00000));
    send_word(word_of(MODE_TRANSLATE, 16'hc000, 16'h0000, 5'b00000));
    send_word(word_of(MODE_TRANSLATE, 16'hdfff, 16'h0000, 5'b00000));
    send_word(word_of(MODE_TRANSLATE, 16'he000, 16'h0000, 5'b00000));
    send_word(word_of(MODE_TRANSLATE, 16'hfeff, 16'h0000, 5'b00000));
    send_word(word_of(MODE_TRANSLATE, 16'hff00, 16'h0000, 5'b00000));
    send_word(word_of(MODE_TRANSLATE, 16'hffff, 16'h0000, 5'b00000));
    send_word(word_of(MODE_WRITE, 16'h0000, 16'h081b, 5'b10000));
    send_word(word_of(MODE_TRANSLATE, 16'h8002, 16'h0000, 5'b00000));
    send_word(word_of(MODE_WRITE, 16'h0000, 16'h0808, 5'b10000));
    send_word(word_of(MODE_WRITE, 16'h0000, 16'h0802, 5'b10000));
    send_word(word_of(MODE_WRITE, 16'h0000, 16'h0801, 5'b10000));
    send_word(word_of(MODE_WRITE, 16'h0000, 16'h7f00, 5'b00000));
    send_word(word_of(MODE_TRANSLATE, 16'h7ffe, 16'h0000, 5'b00000));
    send_word(word_of(MODE_TRANSLATE, 16'h8000, 16'h0000, 5'b00000));
    send_word(word_of(MODE_WRITE, 16'h0000, 16'h0040, 5'b10000));
    send_word(word_of(MODE_WRITE, 16'h0000, 16'h00ff, 5'b00000));
    send_word(word_of(MODE_WRITE, 16'h0000, 16'h0080, 5'b11000));
    send_word(word_of(MODE_WRITE, 16'h0000, 16'h00c0, 5'b11100));
    send_word(word_of(MODE_READ, 16'h0000, 16'h0000, 5'b01010));
    send_word(word_of(MODE_READ, 16'h0000, 16'h0000, 5'b01011));
    send_word(word_of(MODE_UNUSED, 16'hffff, 16'hffff, 5'b11111));

    write_disk(1'b1);
    send_word(word_of(MODE_TRANSLATE, 16'he000, 16'h0000, 5'b00000));
    send_word(word_of(MODE_TRANSLATE, 16'hfdff, 16'h0000, 5'b00000));
    send_word(word_of(MODE_TRANSLATE, 16'hfe00, 16'h0000, 5'b00000));
    send_word(word_of(MODE_TRANSLATE, 16'hffff, 16'h0000, 5'b00000));

    for (int phase = 0; phase < 4; phase++) begin
      write_disk(phase[0]);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 35 == 0) begin
          sender_quiet = ($urandom_range(0, 3) == 0);
          receiver_quiet = ($urandom_range(0, 3) == 0);
        end
        send_word(random_word());
      end
    end

    drain_results();
    $display("Covered %0d words: %0d translations, %0d port writes, %0d port reads, %0d unused.",
             sb.mode_count[0] + sb.mode_count[1] + sb.mode_count[2] + sb.mode_count[3],
             sb.mode_count[0], sb.mode_count[1], sb.mode_count[2], sb.mode_count[3]);
    $display("%0d results checked across %0d disk setting writes, %0d mismatches.",
             sb.checked, cfg_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
